### src/rght_pkg.sv
// ----------------------------------------------------------------------------
// rght_pkg: types and constants for the generational handle table
// Shared item types, command and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package rght_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int GEN_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam logic [GEN_BITS-1:0] GEN_LIMIT = 16'hFFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DERIVE  = 3'd1,
    CMD_RETAIN  = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_INSPECT = 3'd4
  } cmd_code_t;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NONCANON      = 3'd1;
  localparam logic [2:0] ST_BADKEY        = 3'd2;
  localparam logic [2:0] ST_NOTLIVE       = 3'd3;
  localparam logic [2:0] ST_SATURATED     = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED     = 3'd5;
  localparam logic [2:0] ST_NOTRESTRICTED = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  key_slot;
    logic [15:0] key_generation;
    logic [63:0] cap_effective;
    logic [63:0] cap_permitted;
    logic [63:0] cap_inheritable;
    logic [63:0] cap_bounding;
    logic [2:0]  integrity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_slot;
    logic [15:0] out_generation;
    logic        row_live;
    logic [15:0] row_references;
    logic [63:0] row_cap_effective;
    logic [63:0] row_cap_permitted;
    logic [63:0] row_cap_inheritable;
    logic [63:0] row_cap_bounding;
    logic [2:0]  row_integrity;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word, start row read
    logic decide;   // evaluate checks on read row
    logic commit;   // write back and form result
  } rght_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } rght_stat_t;

endpackage

### src/rght_datapath.sv
// ----------------------------------------------------------------------------
// rght_datapath: row storage, free-slot search and command evaluation
// Reads the keyed row into registers, checks it, then writes back one row.
// ----------------------------------------------------------------------------
module rght_datapath import rght_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  in_item_t    in_item,
  input  rght_cmd_t   ctl,
  output out_item_t   res
);

  logic [SLOT_COUNT-1:0] live_r;
  logic [SLOT_COUNT-1:0] gen_ok_r;   // generation below limit
  logic [GEN_BITS-1:0]   gen_mem [SLOT_COUNT];
  logic [COUNT_BITS-1:0] cnt_mem [SLOT_COUNT];
  logic [255:0]          mask_mem [SLOT_COUNT];
  logic [2:0]            integ_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] gvalid_r;   // gen/count entry written since reset

  logic [63:0]           known_r;
  in_item_t              item_r;
  logic [GEN_BITS-1:0]   rgen_r, agen_r;
  logic [COUNT_BITS-1:0] rcnt_r;
  logic [255:0]          rmask_r;
  logic [2:0]            rinteg_r;
  logic                  rlive_r;
  logic                  free_r;
  logic [SLOT_BITS-1:0]  free_slot_r;
  logic                  canon_r;
  logic [2:0]            st_r, st_nxt;
  logic                  alloc_r, wcnt_r, kill_r;
  logic                  alloc_nxt, wcnt_nxt, kill_nxt;
  logic [COUNT_BITS-1:0] ncnt_r, ncnt_nxt;
  out_item_t             res_r, res_nxt;

  logic [SLOT_COUNT-1:0] usable;
  logic                  free_any;
  logic [SLOT_BITS-1:0]  free_idx;
  logic [255:0]          m;

  assign usable = ~live_r & gen_ok_r;
  assign m = {in_item.cap_effective, in_item.cap_permitted,
              in_item.cap_inheritable, in_item.cap_bounding};

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (usable[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  // stage 1: capture, read row, search, canonical check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '1;
    end else if (cfg_we) begin
      known_r <= cfg_data;
    end
    if (ctl.load) begin
      item_r      <= in_item;
      rgen_r      <= gvalid_r[in_item.key_slot] ? gen_mem[in_item.key_slot] : '0;
      rcnt_r      <= gvalid_r[in_item.key_slot] ? cnt_mem[in_item.key_slot] : '0;
      rmask_r     <= mask_mem[in_item.key_slot];
      rinteg_r    <= integ_mem[in_item.key_slot];
      rlive_r     <= live_r[in_item.key_slot];
      free_r      <= free_any;
      free_slot_r <= free_idx;
      agen_r      <= gvalid_r[free_idx] ? gen_mem[free_idx] : '0;
      canon_r     <= ((m[255:192] | m[191:128] | m[127:64] | m[63:0]) & ~known_r) == '0
                     && (in_item.cap_effective & ~in_item.cap_permitted) == '0
                     && (in_item.cap_permitted & ~in_item.cap_bounding) == '0
                     && (in_item.cap_inheritable & ~in_item.cap_bounding) == '0
                     && in_item.integrity <= 3'd4;
    end
  end

  // stage 2: decide
  logic key_ok, live_ok, restr_ok;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
  assign key_ok = item_r.key_generation != '0 && rgen_r == item_r.key_generation;
  assign live_ok = rlive_r && rcnt_r != '0;
  assign restr_ok = (item_r.cap_effective & ~rmask_r[255:192]) == '0
                 && (item_r.cap_permitted & ~rmask_r[191:128]) == '0
                 && (item_r.cap_inheritable & ~rmask_r[127:64]) == '0
                 && (item_r.cap_bounding & ~rmask_r[63:0]) == '0
                 && item_r.integrity <= rinteg_r;
  assign cnt_inc = rcnt_r + COUNT_BITS'(1);
  assign cnt_dec = rcnt_r - COUNT_BITS'(1);

  always_comb begin
    alloc_nxt = 1'b0;
    wcnt_nxt  = 1'b0;
    kill_nxt  = 1'b0;
    ncnt_nxt  = rcnt_r;
    st_nxt    = ST_BADKEY;
    case (item_r.command)
      CMD_CREATE, CMD_DERIVE: begin
        if (!canon_r) st_nxt = ST_NONCANON;
        else if (item_r.command == CMD_DERIVE && !key_ok) st_nxt = ST_BADKEY;
        else if (item_r.command == CMD_DERIVE && !live_ok) st_nxt = ST_NOTLIVE;
        else if (item_r.command == CMD_DERIVE && !restr_ok) st_nxt = ST_NOTRESTRICTED;
        else if (!free_r) st_nxt = ST_EXHAUSTED;
        else begin
          st_nxt    = ST_OK;
          alloc_nxt = 1'b1;
        end
      end
      CMD_RETAIN: begin
        if (!key_ok) st_nxt = ST_BADKEY;
        else if (!live_ok) st_nxt = ST_NOTLIVE;
        else if (rcnt_r == COUNT_MAX) st_nxt = ST_SATURATED;
        else begin
          st_nxt   = ST_OK;
          wcnt_nxt = 1'b1;
          ncnt_nxt = cnt_inc;
        end
      end
      CMD_RELEASE: begin
        if (!key_ok) st_nxt = ST_BADKEY;
        else if (!live_ok) st_nxt = ST_NOTLIVE;
        else begin
          st_nxt   = ST_OK;
          wcnt_nxt = 1'b1;
          ncnt_nxt = cnt_dec;
          kill_nxt = cnt_dec == '0;
        end
      end
      CMD_INSPECT: st_nxt = key_ok ? ST_OK : ST_BADKEY;
      default: st_nxt = ST_BADKEY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      alloc_r <= alloc_nxt;
      wcnt_r  <= wcnt_nxt;
      kill_r  <= kill_nxt;
      ncnt_r  <= ncnt_nxt;
      st_r    <= st_nxt;
    end
  end

  // stage 3: write back and form result
  logic [GEN_BITS-1:0] ngen;
  assign ngen = agen_r + GEN_BITS'(1);

  always_comb begin
    res_nxt = '0;
    res_nxt.status = st_r;
    if (alloc_r) begin
      res_nxt.out_slot       = free_slot_r;
      res_nxt.out_generation = ngen;
    end
    if (item_r.command == CMD_INSPECT && st_r == ST_OK) begin
      res_nxt.row_live            = rlive_r;
      res_nxt.row_references      = rcnt_r;
      res_nxt.row_cap_effective   = rmask_r[255:192];
      res_nxt.row_cap_permitted   = rmask_r[191:128];
      res_nxt.row_cap_inheritable = rmask_r[127:64];
      res_nxt.row_cap_bounding    = rmask_r[63:0];
      res_nxt.row_integrity       = rinteg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      gen_ok_r <= '1;
      gvalid_r <= '0;
    end else if (ctl.commit) begin
      if (alloc_r) begin
        live_r[free_slot_r]   <= 1'b1;
        gen_ok_r[free_slot_r] <= ngen < GEN_LIMIT;
        gvalid_r[free_slot_r] <= 1'b1;
      end else if (kill_r) begin
        live_r[item_r.key_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (alloc_r) begin
        gen_mem[free_slot_r]   <= ngen;
        cnt_mem[free_slot_r]   <= COUNT_BITS'(1);
        mask_mem[free_slot_r]  <= {item_r.cap_effective, item_r.cap_permitted,
                                   item_r.cap_inheritable, item_r.cap_bounding};
        integ_mem[free_slot_r] <= item_r.integrity;
      end else if (wcnt_r) begin
        cnt_mem[item_r.key_slot] <= ncnt_r;
      end
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && alloc_r |-> !live_r[free_slot_r])
    else $error("allocating a live row");
  a_kill_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && kill_r |-> ncnt_r == '0)
    else $error("retire with nonzero count");
  a_ok_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && alloc_r |=> res_r.out_generation != '0)
    else $error("zero generation issued");

endmodule

### src/rght_ctrl.sv
// ----------------------------------------------------------------------------
// rght_ctrl: sequencer for the handle table
// Steps load, decide and commit, then holds the result word for the receiver.
// ----------------------------------------------------------------------------
module rght_ctrl import rght_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cfg_ready,
  output rght_cmd_t  ctl,
  output rght_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_COMMIT, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // accept a new word when idle, or when the held result leaves this cycle
  assign in_stall = !(state_r == S_IDLE || (state_r == S_OUT && !out_stall));
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (in_valid) begin
            ctl.load  = 1'b1;
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign stat.done = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("result valid outside output state");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("commit without result");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !in_stall)
    else $error("load while stalled");

endmodule

### src/refcounted_generational_handle_table.sv
// ----------------------------------------------------------------------------
// refcounted_generational_handle_table: keyed row pool with generations
// Create, derive, retain, release and inspect on 64 rows of credentials.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall/in_item; one result word per input
// leaves on out_valid/out_stall/out_item. A word is taken on an edge with
// valid high and stall low.
// Steps: load/read row on the accepting edge, then decide, then write back;
// out_valid rises with the write back. No new word is taken until the held
// result leaves; the next word is taken in the same cycle the held result
// leaves. The three steps of the row read-modify-write run one word at a time.
// While out_stall is high the result holds and no new word is taken.
// cfg_valid/cfg_ready/cfg_data write known_capability_mask (always ready);
// write it only while idle.
// Reset (rst_n low, synchronous) retires every row, zeroes generations and
// counts and sets the mask to all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_generational_handle_table import rght_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  rght_cmd_t  ctl;
  rght_stat_t stat;

  rght_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready),
    .ctl(ctl), .stat(stat)
  );

  rght_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .in_item(in_item), .ctl(ctl), .res(out_item)
  );

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done == out_valid)
    else $error("status mismatch");

endmodule
